// ----- rtl/core/occupancy_grid_scan_update_unit_assert.svh -----
// Assertion macros shared by the occupancy grid RTL.
`ifndef OCCUPANCY_GRID_SCAN_UPDATE_UNIT_ASSERT_SVH
`define OCCUPANCY_GRID_SCAN_UPDATE_UNIT_ASSERT_SVH

// same-cycle implication, held off while reset is asserted
`define OGSU_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define OGSU_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/ogsu_pkg.sv -----
// Types, constants and tables of the occupancy grid scan update unit.
package ogsu_pkg;

  localparam int MAP_WIDTH_DEF  = 256;
  localparam int MAP_HEIGHT_DEF = 256;
  localparam int BEAMS_DEF      = 256;

  localparam int MODE_W     = 2;
  localparam int BIDX_W     = 8;
  localparam int RANGE_W    = 16;
  localparam int POS_W      = 16;
  localparam int ANG_W      = 16;
  localparam int COORD_W    = 8;
  localparam int CELL_W     = 8;
  localparam int CW_W       = 10;
  localparam int STEP_W     = 16;
  localparam int BCNT_W     = 9;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // window loop counters: robot cell plus or minus twice range/width
  localparam int LOOP_W       = 19;
  localparam int DIV_W        = 17;
  localparam int CORDIC_STEPS = 18;
  localparam int ACC_W        = 32;
  localparam int CNT_W        = 5;

  localparam logic [CW_W-1:0]   CW_RST    = 10'd50;
  localparam logic [RANGE_W-1:0] RMAX_RST = 16'd4000;
  localparam logic [STEP_W-1:0] STEP_RST  = 16'd182;
  localparam logic [BCNT_W-1:0] BCNT_RST  = 9'd181;

  localparam logic [CELL_W-1:0] CELL_INIT = 8'd127;
  localparam int CELL_MAX   = 231;
  localparam int CELL_MIN   = 20;
  localparam logic [ANG_W-1:0] FIRST_BEAM = 16'hC000;
  localparam logic signed [4:0] DELTA_OCC  = 5'sd9;
  localparam logic signed [4:0] DELTA_FREE = -5'sd9;
  localparam logic signed [4:0] DELTA_MISS = -5'sd10;
  localparam logic signed [4:0] DELTA_NONE = 5'sd0;

  typedef enum logic [MODE_W-1:0] {
    MODE_STORE,
    MODE_UPDATE,
    MODE_READ,
    MODE_NONE
  } mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CELL_WIDTH,
    CFG_RANGE_MAX,
    CFG_BEAM_STEP,
    CFG_BEAM_COUNT
  } cfg_idx_e;

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_OUT,
    ST_DIV_R,
    ST_DIV_X,
    ST_DIV_Y,
    ST_LIM,
    ST_LIM2,
    ST_ROW,
    ST_COL,
    ST_MX,
    ST_MY,
    ST_SQX,
    ST_SQY,
    ST_RANGE,
    ST_CINIT,
    ST_CORD,
    ST_EX2,
    ST_EY2,
    ST_QSUM,
    ST_BEAM,
    ST_SRD,
    ST_SWAIT,
    ST_C1,
    ST_C2,
    ST_C3,
    ST_C4,
    ST_MWR
  } state_e;

  // atan(2^-i) as a fraction of a turn, 32-bit
  function automatic logic [ACC_W-1:0] atan_turn(input logic [CNT_W-1:0] i);
    logic [ACC_W-1:0] r;
    case (i)
      5'd0:    r = 32'h20000000;
      5'd1:    r = 32'h12E4051D;
      5'd2:    r = 32'h09FB385B;
      5'd3:    r = 32'h051111D4;
      5'd4:    r = 32'h028B0D43;
      5'd5:    r = 32'h0145D7E1;
      5'd6:    r = 32'h00A2F61E;
      5'd7:    r = 32'h00517C55;
      5'd8:    r = 32'h0028BE53;
      5'd9:    r = 32'h00145F2E;
      5'd10:   r = 32'h000A2F98;
      5'd11:   r = 32'h000517CC;
      5'd12:   r = 32'h00028BE6;
      5'd13:   r = 32'h000145F3;
      5'd14:   r = 32'h0000A2F9;
      5'd15:   r = 32'h0000517C;
      5'd16:   r = 32'h000028BE;
      5'd17:   r = 32'h0000145F;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// ----- rtl/core/ogsu_if.sv -----
// Valid/ready channels of the occupancy grid unit: input item and result item.
interface ogsu_in_if import ogsu_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [MODE_W-1:0]         mode;
  logic [BIDX_W-1:0]         beam_index;
  logic [RANGE_W-1:0]        range_reading;
  logic signed [POS_W-1:0]   robot_x;
  logic signed [POS_W-1:0]   robot_y;
  logic [ANG_W-1:0]          robot_heading;
  logic [COORD_W-1:0]        cell_x;
  logic [COORD_W-1:0]        cell_y;

  modport source (output valid, mode, beam_index, range_reading, robot_x, robot_y,
                  robot_heading, cell_x, cell_y, input ready);
  modport sink (input valid, mode, beam_index, range_reading, robot_x, robot_y,
                robot_heading, cell_x, cell_y, output ready);
endinterface

interface ogsu_out_if import ogsu_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CELL_W-1:0] cell_value;
  logic              update_done;

  modport source (output valid, cell_value, update_done, input ready);
  modport sink (input valid, cell_value, update_done, output ready);
endinterface

// ----- rtl/core/ogsu_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module ogsu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// ----- rtl/core/occupancy_grid_scan_update_unit.sv -----
// Occupancy grid scan update unit: byte map updated from a stored range scan.
// Reset: config registers load defaults, then a clearing pass writes 127 to all
//   MAP_WIDTH*MAP_HEIGHT cells; no item is taken meanwhile.
// Store items go straight to the result, reads via a map read state; one item at a time.
// Update (none if cell width is 0): setup of three divisions, a row step per row, then per
//   window cell a range test, and if in range an 18-step CORDIC, beam scan and map update.
`include "occupancy_grid_scan_update_unit_assert.svh"

module occupancy_grid_scan_update_unit import ogsu_pkg::*; #(
  parameter int MAP_WIDTH  = MAP_WIDTH_DEF,
  parameter int MAP_HEIGHT = MAP_HEIGHT_DEF,
  parameter int BEAMS      = BEAMS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  ogsu_in_if.sink               in_if,
  ogsu_out_if.source            out_if,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  localparam int XW      = $clog2(MAP_WIDTH);
  localparam int YW      = $clog2(MAP_HEIGHT);
  localparam int MA_W    = $clog2(MAP_WIDTH * MAP_HEIGHT);
  localparam int BA_W    = $clog2(BEAMS);
  localparam int MAX_DIM = (MAP_WIDTH > MAP_HEIGHT) ? MAP_WIDTH : MAP_HEIGHT;
  localparam int DX_W    = $clog2(2 * MAX_DIM * 1024 + 65536) + 1;
  localparam int MUL_W   = (DX_W > 19) ? DX_W : 19;
  localparam int P_W     = 2 * MUL_W;
  localparam int CX_W    = DX_W + 10;

  state_e state_q, state_d;

  logic [CW_W-1:0]    cw_q;
  logic [RANGE_W-1:0] rmax_q;
  logic [STEP_W-1:0]  step_q;
  logic [BCNT_W-1:0]  bcnt_q;
  logic [MA_W-1:0]    clr_q;

  // item and result registers
  logic signed [POS_W-1:0] px_q, py_q;
  logic [ANG_W-1:0]        head_q;
  logic                    rd_ok_q;
  logic [CELL_W-1:0]       cell_value_q;
  logic                    update_done_q;

  // divider
  logic [DIV_W-1:0]  dq_q, dq_d;
  logic [CW_W-1:0]   dr_q, dr_d;
  logic [CW_W:0]     trial;
  logic              ge;
  logic [CNT_W-1:0]  cnt_q;
  logic [LOOP_W-2:0] rm_q;
  logic signed [LOOP_W-1:0] q_s, q_signed, rm_s;
  logic [DIV_W-1:0]  px_mag, py_mag;

  // window loop
  logic signed [LOOP_W-1:0] y_q, yend_q, x_q, xend_q, xstart_q;
  logic [XW-1:0] xc_q, xc;
  logic [YW-1:0] yc_q, yc;
  logic [MA_W-1:0] cell_idx, rd_idx;

  // shared multiplier
  logic signed [MUL_W-1:0] mul_a, mul_b;
  logic signed [P_W-1:0]   prod_q, lim2_q, t_q, qd_q;
  logic signed [DX_W-1:0]  ex_q, ey_q, dx_w, dy_w;

  // CORDIC
  logic signed [CX_W-1:0] cx_q, cy_q, cx_sh, cy_sh;
  logic [ACC_W-1:0]       acc_q, acc_d;
  logic [ANG_W-1:0]       ang_q;
  logic                   dx_neg;

  // beam search and model
  logic [ANG_W-1:0]  phi_q, ba_q, best_q, dabs;
  logic signed [ANG_W:0] bdiff;
  logic [BA_W-1:0]   i_q, k_q, nm1_q, nm1;
  logic [RANGE_W-1:0] s_q;
  logic [CW_W:0]     hh;
  logic [RANGE_W:0]  sph_w, m_w;
  logic signed [RANGE_W+1:0] smh_w;
  logic              far_q, hi_q, lo_q, free_w, occ_w;
  logic signed [4:0] delta_q, delta_w;
  logic signed [CELL_W+1:0] vsum;
  logic [CELL_W-1:0] vclamp;

  // memories
  logic                map_we;
  logic [MA_W-1:0]     map_waddr, map_raddr;
  logic [CELL_W-1:0]   map_wdata, map_rdata;
  logic                beam_we;
  logic [BA_W-1:0]     beam_raddr;
  logic [RANGE_W-1:0]  beam_rdata;

  logic in_fire, out_fire, bidx_ok, cell_ok;

  assign in_fire  = in_if.valid & in_if.ready;
  assign out_fire = out_if.valid & out_if.ready;
  assign bidx_ok  = int'(in_if.beam_index) < BEAMS;
  assign cell_ok  = (int'(in_if.cell_x) < MAP_WIDTH) && (int'(in_if.cell_y) < MAP_HEIGHT);

  // ---------------- divider step ----------------
  assign trial = {dr_q, dq_q[DIV_W-1]};
  assign ge    = trial >= {1'b0, cw_q};
  assign dr_d  = ge ? CW_W'(trial - {1'b0, cw_q}) : trial[CW_W-1:0];
  assign dq_d  = {dq_q[DIV_W-2:0], ge};
  assign q_s   = $signed({2'b00, dq_d});
  assign rm_s  = $signed({1'b0, rm_q});
  assign px_mag = px_q[POS_W-1] ? DIV_W'(17'd0 - {px_q[POS_W-1], px_q}) : DIV_W'(px_q);
  assign py_mag = py_q[POS_W-1] ? DIV_W'(17'd0 - {py_q[POS_W-1], py_q}) : DIV_W'(py_q);
  always_comb begin
    q_signed = q_s;
    if (state_q == ST_DIV_X && px_q[POS_W-1]) begin
      q_signed = -q_s;
    end else if (state_q == ST_DIV_Y && py_q[POS_W-1]) begin
      q_signed = -q_s;
    end
  end

  // ---------------- window clamp ----------------
  always_comb begin
    if (y_q < 0) begin
      yc = '0;
    end else if (y_q > $signed(LOOP_W'(MAP_HEIGHT - 1))) begin
      yc = YW'(MAP_HEIGHT - 1);
    end else begin
      yc = y_q[YW-1:0];
    end
    if (x_q < 0) begin
      xc = '0;
    end else if (x_q > $signed(LOOP_W'(MAP_WIDTH - 1))) begin
      xc = XW'(MAP_WIDTH - 1);
    end else begin
      xc = x_q[XW-1:0];
    end
  end

  assign cell_idx = MA_W'(yc_q) * MA_W'(MAP_WIDTH) + MA_W'(xc_q);
  assign rd_idx   = MA_W'(in_if.cell_y) * MA_W'(MAP_WIDTH) + MA_W'(in_if.cell_x);

  // doubled center offsets in mm: 2*(x*cw - px) + cw
  assign dx_w = DX_W'(ex_q <<< 1) + DX_W'($signed({1'b0, cw_q}));
  assign dy_w = DX_W'(ey_q <<< 1) + DX_W'($signed({1'b0, cw_q}));
  assign dx_neg = dx_w < 0;

  // ---------------- CORDIC step ----------------
  assign cx_sh = cx_q >>> cnt_q;
  assign cy_sh = cy_q >>> cnt_q;
  always_comb begin
    if (cy_q > 0) begin
      acc_d = acc_q + atan_turn(cnt_q);
    end else begin
      acc_d = acc_q - atan_turn(cnt_q);
    end
  end

  // ---------------- beam search ----------------
  assign bdiff = $signed({1'b0, phi_q}) - $signed({1'b0, ba_q});
  assign dabs  = bdiff[ANG_W] ? ANG_W'(-bdiff) : bdiff[ANG_W-1:0];
  always_comb begin
    if (bcnt_q == '0) begin
      nm1 = '0;
    end else if (int'(bcnt_q) > BEAMS) begin
      nm1 = BA_W'(BEAMS - 1);
    end else begin
      nm1 = BA_W'(bcnt_q - 1'b1);
    end
  end

  // ---------------- sensor model ----------------
  assign hh     = {cw_q, 1'b0};
  assign sph_w  = {1'b0, beam_rdata} + (RANGE_W+1)'(hh);
  assign m_w    = ({1'b0, rmax_q} > sph_w) ? sph_w : {1'b0, rmax_q};
  assign smh_w  = $signed({2'b00, s_q}) - $signed((RANGE_W+2)'(hh));
  assign free_w = qd_q <= prod_q;
  assign occ_w  = (s_q < rmax_q) && hi_q && lo_q;
  always_comb begin
    if (far_q) begin
      delta_w = DELTA_NONE;
    end else if (occ_w) begin
      delta_w = DELTA_OCC;
    end else if (free_w) begin
      delta_w = DELTA_FREE;
    end else begin
      delta_w = DELTA_MISS;
    end
  end

  assign vsum = $signed({2'b00, map_rdata}) + (CELL_W+2)'(delta_q);
  always_comb begin
    if (vsum >= $signed((CELL_W+2)'(CELL_MAX))) begin
      vclamp = CELL_W'(CELL_MAX);
    end else if (vsum <= $signed((CELL_W+2)'(CELL_MIN))) begin
      vclamp = CELL_W'(CELL_MIN);
    end else begin
      vclamp = vsum[CELL_W-1:0];
    end
  end

  // ---------------- next state ----------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (clr_q == MA_W'(MAP_WIDTH * MAP_HEIGHT - 1)) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_fire) begin
          case (mode_e'(in_if.mode))
            MODE_READ:   state_d = ST_READ;
            MODE_UPDATE: state_d = (cw_q == '0) ? ST_OUT : ST_DIV_R;
            default:     state_d = ST_OUT;
          endcase
        end
      end
      ST_READ:  state_d = ST_OUT;
      ST_OUT:   if (out_fire) state_d = ST_IDLE;
      ST_DIV_R: if (cnt_q == CNT_W'(DIV_W - 1)) state_d = ST_DIV_X;
      ST_DIV_X: if (cnt_q == CNT_W'(DIV_W - 1)) state_d = ST_DIV_Y;
      ST_DIV_Y: if (cnt_q == CNT_W'(DIV_W - 1)) state_d = ST_LIM;
      ST_LIM:   state_d = ST_LIM2;
      ST_LIM2:  state_d = ST_ROW;
      ST_ROW: begin
        if (y_q == $signed(LOOP_W'(MAP_HEIGHT)) || y_q == yend_q) state_d = ST_OUT;
        else state_d = ST_COL;
      end
      ST_COL: begin
        if (x_q == $signed(LOOP_W'(MAP_WIDTH)) || x_q == xend_q) state_d = ST_ROW;
        else state_d = ST_MX;
      end
      ST_MX:    state_d = ST_MY;
      ST_MY:    state_d = ST_SQX;
      ST_SQX:   state_d = ST_SQY;
      ST_SQY:   state_d = ST_RANGE;
      ST_RANGE: state_d = (t_q + prod_q >= lim2_q) ? ST_COL : ST_CINIT;
      ST_CINIT: state_d = (dx_w == '0 && dy_w == '0) ? ST_EX2 : ST_CORD;
      ST_CORD:  if (cnt_q == CNT_W'(CORDIC_STEPS - 1)) state_d = ST_EX2;
      ST_EX2:   state_d = ST_EY2;
      ST_EY2:   state_d = ST_QSUM;
      ST_QSUM:  state_d = ST_BEAM;
      ST_BEAM:  if (i_q == nm1_q) state_d = ST_SRD;
      ST_SRD:   state_d = ST_SWAIT;
      ST_SWAIT: state_d = ST_C1;
      ST_C1:    state_d = ST_C2;
      ST_C2:    state_d = ST_C3;
      ST_C3:    state_d = ST_C4;
      ST_C4:    state_d = ST_MWR;
      ST_MWR:   state_d = ST_COL;
      default:  state_d = ST_IDLE;
    endcase
  end

  // ---------------- outputs and unit controls ----------------
  always_comb begin
    in_if.ready = (state_q == ST_IDLE);
    out_if.valid = (state_q == ST_OUT);
    out_if.cell_value = cell_value_q;
    out_if.update_done = update_done_q;
    mul_a = '0;
    mul_b = '0;
    map_we = 1'b0;
    map_waddr = cell_idx;
    map_wdata = vclamp;
    map_raddr = rd_idx;
    beam_we = (state_q == ST_IDLE) && in_fire && (mode_e'(in_if.mode) == MODE_STORE) && bidx_ok;
    beam_raddr = k_q;
    case (state_q)
      ST_CLEAR: begin
        map_we = 1'b1;
        map_waddr = clr_q;
        map_wdata = CELL_INIT;
      end
      ST_LIM: begin
        mul_a = MUL_W'($signed({1'b0, rmax_q, 1'b0}));
        mul_b = MUL_W'($signed({1'b0, rmax_q, 1'b0}));
      end
      ST_MX: begin
        mul_a = MUL_W'($signed({1'b0, xc_q}));
        mul_b = MUL_W'($signed({1'b0, cw_q}));
      end
      ST_MY: begin
        mul_a = MUL_W'($signed({1'b0, yc_q}));
        mul_b = MUL_W'($signed({1'b0, cw_q}));
      end
      ST_SQX: begin
        mul_a = MUL_W'(dx_w);
        mul_b = MUL_W'(dx_w);
      end
      ST_SQY: begin
        mul_a = MUL_W'(dy_w);
        mul_b = MUL_W'(dy_w);
      end
      ST_EX2: begin
        mul_a = MUL_W'(ex_q);
        mul_b = MUL_W'(ex_q);
      end
      ST_EY2: begin
        mul_a = MUL_W'(ey_q);
        mul_b = MUL_W'(ey_q);
      end
      ST_SWAIT: begin
        mul_a = MUL_W'($signed({1'b0, m_w}));
        mul_b = MUL_W'($signed({1'b0, m_w}));
      end
      ST_C1: begin
        mul_a = MUL_W'($signed({1'b0, {1'b0, s_q} + (RANGE_W+1)'(hh)}));
        mul_b = MUL_W'($signed({1'b0, {1'b0, s_q} + (RANGE_W+1)'(hh)}));
      end
      ST_C2: begin
        mul_a = MUL_W'(smh_w);
        mul_b = MUL_W'(smh_w);
      end
      ST_C3: begin
        mul_a = MUL_W'($signed({1'b0, s_q}));
        mul_b = MUL_W'($signed({1'b0, s_q}));
      end
      ST_C4: begin
        map_raddr = cell_idx;
      end
      ST_MWR: begin
        map_we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // ---------------- control registers ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
      cw_q    <= CW_RST;
      rmax_q  <= RMAX_RST;
      step_q  <= STEP_RST;
      bcnt_q  <= BCNT_RST;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLEAR) clr_q <= clr_q + 1'b1;
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_CELL_WIDTH: cw_q   <= cfg_wdata_i[CW_W-1:0];
          CFG_RANGE_MAX:  rmax_q <= cfg_wdata_i[RANGE_W-1:0];
          CFG_BEAM_STEP:  step_q <= cfg_wdata_i[STEP_W-1:0];
          CFG_BEAM_COUNT: bcnt_q <= cfg_wdata_i[BCNT_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  // ---------------- datapath registers ----------------
  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    case (state_q)
      ST_IDLE: begin
        px_q <= in_if.robot_x;
        py_q <= in_if.robot_y;
        head_q <= in_if.robot_heading;
        rd_ok_q <= cell_ok;
        cell_value_q <= '0;
        update_done_q <= (mode_e'(in_if.mode) == MODE_UPDATE);
        dq_q <= DIV_W'(rmax_q);
        dr_q <= '0;
        cnt_q <= '0;
        nm1_q <= nm1;
      end
      ST_READ: begin
        cell_value_q <= rd_ok_q ? map_rdata : '0;
      end
      ST_DIV_R, ST_DIV_X, ST_DIV_Y: begin
        dq_q <= dq_d;
        dr_q <= dr_d;
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_W'(DIV_W - 1)) begin
          dr_q <= '0;
          cnt_q <= '0;
          if (state_q == ST_DIV_R) begin
            rm_q <= {dq_d, 1'b0};
            dq_q <= px_mag;
          end else if (state_q == ST_DIV_X) begin
            xstart_q <= q_signed - rm_s;
            xend_q <= q_signed + rm_s;
            dq_q <= py_mag;
          end else begin
            y_q <= q_signed - rm_s;
            yend_q <= q_signed + rm_s;
          end
        end
      end
      ST_LIM2: begin
        lim2_q <= prod_q;
      end
      ST_ROW: begin
        yc_q <= yc;
        x_q <= xstart_q;
      end
      ST_COL: begin
        xc_q <= xc;
        if (x_q == $signed(LOOP_W'(MAP_WIDTH)) || x_q == xend_q) begin
          y_q <= LOOP_W'($signed({1'b0, yc_q})) + LOOP_W'(1);
        end
      end
      ST_MY: begin
        ex_q <= DX_W'(prod_q) - DX_W'(px_q);
      end
      ST_SQX: begin
        ey_q <= DX_W'(prod_q) - DX_W'(py_q);
      end
      ST_SQY: begin
        t_q <= prod_q;
      end
      ST_RANGE: begin
        if (t_q + prod_q >= lim2_q) x_q <= LOOP_W'($signed({1'b0, xc_q})) + LOOP_W'(1);
      end
      ST_CINIT: begin
        cnt_q <= '0;
        ang_q <= '0;
        cx_q <= (dx_neg ? -CX_W'(dx_w) : CX_W'(dx_w)) <<< 8;
        cy_q <= (dx_neg ? -CX_W'(dy_w) : CX_W'(dy_w)) <<< 8;
        acc_q <= dx_neg ? 32'h80000000 : 32'h0;
      end
      ST_CORD: begin
        if (cy_q > 0) begin
          cx_q <= cx_q + cy_sh;
          cy_q <= cy_q - cx_sh;
        end else begin
          cx_q <= cx_q - cy_sh;
          cy_q <= cy_q + cx_sh;
        end
        acc_q <= acc_d;
        cnt_q <= cnt_q + 1'b1;
        ang_q <= ANG_W'((acc_d + 32'h8000) >> 16);
      end
      ST_EY2: begin
        t_q <= prod_q;
      end
      ST_QSUM: begin
        qd_q <= t_q + prod_q;
        phi_q <= ang_q - head_q;
        ba_q <= FIRST_BEAM;
        i_q <= '0;
      end
      ST_BEAM: begin
        if (i_q == '0 || dabs < best_q) begin
          best_q <= dabs;
          k_q <= i_q;
        end
        i_q <= i_q + 1'b1;
        ba_q <= ba_q + step_q;
      end
      ST_SWAIT: begin
        s_q <= beam_rdata;
      end
      ST_C1: begin
        far_q <= (qd_q > prod_q) || ({best_q, 1'b0} > {1'b0, step_q});
      end
      ST_C2: begin
        hi_q <= qd_q < prod_q;
      end
      ST_C3: begin
        lo_q <= (s_q < RANGE_W'(hh)) || (qd_q > prod_q);
      end
      ST_C4: begin
        delta_q <= delta_w;
      end
      ST_MWR: begin
        x_q <= LOOP_W'($signed({1'b0, xc_q})) + LOOP_W'(1);
      end
      default: begin
      end
    endcase
  end

  ogsu_ram #(
    .WIDTH(CELL_W),
    .DEPTH(MAP_WIDTH * MAP_HEIGHT)
  ) u_map_ram (
    .clk_i  (clk_i),
    .we_i   (map_we),
    .waddr_i(map_waddr),
    .wdata_i(map_wdata),
    .raddr_i(map_raddr),
    .rdata_o(map_rdata)
  );

  ogsu_ram #(
    .WIDTH(RANGE_W),
    .DEPTH(BEAMS)
  ) u_beam_ram (
    .clk_i  (clk_i),
    .we_i   (beam_we),
    .waddr_i(BA_W'(in_if.beam_index)),
    .wdata_i(in_if.range_reading),
    .raddr_i(beam_raddr),
    .rdata_o(beam_rdata)
  );

  `OGSU_ASSERT_IMP(a_one_item, clk_i, rst_ni, in_if.ready, !out_if.valid, "ready with result pending")
  `OGSU_ASSERT_IMP(a_map_clamp, clk_i, rst_ni, map_we && state_q == ST_MWR, (map_wdata >= CELL_W'(CELL_MIN)) && (map_wdata <= CELL_W'(CELL_MAX)), "map write out of range")
  `OGSU_ASSERT_IMP(a_beam_bound, clk_i, rst_ni, state_q == ST_BEAM, i_q <= nm1_q, "beam scan overrun")
  `OGSU_ASSERT_NXT(a_busy_after_accept, clk_i, rst_ni, in_fire, !in_if.ready, "ready right after accept")

endmodule
